// ===== hdl/pdpr_pkg.sv =====
// Shared types and constants for the power demand packet rewriter.
// No dependencies; imported by every module of the block.
`default_nettype none

package pdpr_pkg;

   localparam int PACKET_BYTES_DEF = 8;
   localparam int BYTE_W           = 8;
   localparam int CEIL_W           = 12;
   localparam int OFFS_W           = 10;
   localparam int CSUM_W           = 9;
   localparam int DEMAND_W         = 12;
   localparam int RUN_W            = 8;
   localparam int ALU_W            = 17;
   localparam int CSR_IDX_W        = 3;
   localparam int CSR_DATA_W       = 12;

   // store positions of the power field (high, low)
   localparam int PWR_HI_POS = 4;
   localparam int PWR_LO_POS = 5;

   localparam logic [CEIL_W-1:0] CEIL_RST  = CEIL_W'(3000);
   localparam logic [OFFS_W-1:0] DEF_RST   = OFFS_W'(350);
   localparam logic [OFFS_W-1:0] THIRD_RST = OFFS_W'(250);
   localparam logic [OFFS_W-1:0] FOURTH_RST = OFFS_W'(150);
   localparam logic [CSUM_W-1:0] CSUM_RST  = CSUM_W'(264);

   localparam logic [RUN_W-1:0] RUN_THIRD  = RUN_W'(3);
   localparam logic [RUN_W-1:0] RUN_FOURTH = RUN_W'(4);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_CEILING = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DEF_OFS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_THIRD   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FOURTH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CSUM    = 3'd4;

   // operations of the shared adder
   localparam logic ALU_ADD = 1'b0;
   localparam logic ALU_SUB = 1'b1;

   typedef struct packed {
      logic             op;
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
   } alu_req_type;

endpackage

`default_nettype wire

// ===== hdl/power_demand_packet_rewriter_unit.sv =====
// Top level: packet store, demand sequencer and output word register.
// Depends on pdpr_pkg and pdpr_alu.
//
//   channel | direction | tdata          | tuser     | tlast
//   req_    | in        | byte_value[7:0]| operation | packet_end
//   rsp_    | out       | out_byte[7:0]  | -         | out_last
//   csr_    | in        | write only, index 0..4, 12-bit data
//
// Packet bytes are accepted while the sequencer is idle; the last byte of a packet
// adds an offset add and a ceiling compare on the shared adder.
// A tick runs the average and two checksum steps on the adder, then eight
// output words, one per cycle while not held, through the single output register.
// rsp_tready low holds the emit sequence; req_tready is low until it ends.
// Reset is synchronous; all registers but acc_ff, rsp_data_ff and rsp_last_ff get defaults.
`default_nettype none

module power_demand_packet_rewriter_unit
   import pdpr_pkg::*;
#(
   parameter int PACKET_BYTES = PACKET_BYTES_DEF
)(
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   input  wire  [BYTE_W-1:0]     req_tdata,   // [7:0] byte_value
   input  wire                   req_tuser,   // [0] operation
   input  wire                   req_tlast,
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   output logic [BYTE_W-1:0]     rsp_tdata,   // [7:0] out_byte
   output logic                  rsp_tlast,
   input  wire                   csr_we,
   input  wire  [CSR_IDX_W-1:0]  csr_index,
   input  wire  [CSR_DATA_W-1:0] csr_wdata
);

   localparam int POS_W = $clog2(PACKET_BYTES + 1);
   localparam int IDX_W = $clog2(PACKET_BYTES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PACKET_BYTES - 1);
   localparam logic [POS_W-1:0] POS_FULL = POS_W'(PACKET_BYTES);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_FIN   = 3'd1;
   localparam logic [2:0] S_CLAMP = 3'd2;
   localparam logic [2:0] S_AVG   = 3'd3;
   localparam logic [2:0] S_CSUM1 = 3'd4;
   localparam logic [2:0] S_CSUM2 = 3'd5;
   localparam logic [2:0] S_EMIT  = 3'd6;

   logic [CEIL_W-1:0]   ceiling_ff, ceiling_in;
   logic [OFFS_W-1:0]   def_ofs_ff, def_ofs_in;
   logic [OFFS_W-1:0]   third_ff, third_in;
   logic [OFFS_W-1:0]   fourth_ff, fourth_in;
   logic [CSUM_W-1:0]   csum_ff, csum_in;

   logic [BYTE_W-1:0]   store_ff [PACKET_BYTES];
   logic [BYTE_W-1:0]   store_in [PACKET_BYTES];
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [DEMAND_W-1:0] now_ff, now_in;
   logic [DEMAND_W-1:0] prev_ff, prev_in;
   logic [RUN_W-1:0]    run_ff, run_in;
   logic [OFFS_W-1:0]   offset_ff, offset_in;

   logic [2:0]          state_ff, state_in;
   logic [ALU_W-1:0]    acc_ff, acc_in;
   logic [IDX_W-1:0]    emit_idx_ff, emit_idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                rsp_last_ff, rsp_last_in;

   alu_req_type         alu_req;
   logic [ALU_W-1:0]    alu_res;
   logic [15:0]         raw;
   logic                req_fire;
   logic                out_free;

   pdpr_alu u_alu (
      .req    (alu_req),
      .result (alu_res)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign raw        = {store_ff[PWR_HI_POS], store_ff[PWR_LO_POS]};
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      ceiling_in = ceiling_ff;
      def_ofs_in = def_ofs_ff;
      third_in   = third_ff;
      fourth_in  = fourth_ff;
      csum_in    = csum_ff;
      if (csr_we) begin
         case (csr_index)
            REG_CEILING: ceiling_in = csr_wdata[CEIL_W-1:0];
            REG_DEF_OFS: def_ofs_in = csr_wdata[OFFS_W-1:0];
            REG_THIRD:   third_in   = csr_wdata[OFFS_W-1:0];
            REG_FOURTH:  fourth_in  = csr_wdata[OFFS_W-1:0];
            REG_CSUM:    csum_in    = csr_wdata[CSUM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      store_in     = store_ff;
      pos_in       = pos_ff;
      now_in       = now_ff;
      prev_in      = prev_ff;
      run_in       = run_ff;
      offset_in    = offset_ff;
      state_in     = state_ff;
      acc_in       = acc_ff;
      emit_idx_in  = emit_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      alu_req.op   = ALU_ADD;
      alu_req.a    = ALU_W'(raw);
      alu_req.b    = ALU_W'(offset_ff);

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_tuser) begin
                  state_in = S_AVG;
               end else begin
                  if (pos_ff < POS_FULL) begin
                     store_in[pos_ff[IDX_W-1:0]] = req_tdata;
                     pos_in = pos_ff + POS_W'(1);
                  end
                  if (req_tlast) begin
                     pos_in   = '0;
                     state_in = S_FIN;
                  end
               end
            end
         end
         S_FIN: begin
            if (raw[15]) begin
               run_in = run_ff + RUN_W'(1);
               if (run_in == RUN_THIRD) begin
                  offset_in = third_ff;
               end else if (run_in == RUN_FOURTH) begin
                  offset_in = fourth_ff;
               end else begin
                  offset_in = def_ofs_ff;
               end
               acc_in = ALU_W'(offset_in);
            end else begin
               run_in = '0;
               acc_in = alu_res;
            end
            state_in = S_CLAMP;
         end
         S_CLAMP: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = ALU_W'(ceiling_ff);
            alu_req.b  = acc_ff;
            now_in     = alu_res[ALU_W-1] ? ceiling_ff : acc_ff[DEMAND_W-1:0];
            state_in   = S_IDLE;
         end
         S_AVG: begin
            alu_req.op = ALU_ADD;
            alu_req.a  = ALU_W'(now_ff);
            alu_req.b  = ALU_W'(prev_ff);
            store_in[PWR_HI_POS] = BYTE_W'(alu_res[ALU_W-1:9]);
            store_in[PWR_LO_POS] = alu_res[8:1];
            state_in   = S_CSUM1;
         end
         S_CSUM1: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = ALU_W'(csum_ff);
            alu_req.b  = ALU_W'(store_ff[PWR_HI_POS]);
            acc_in     = alu_res;
            state_in   = S_CSUM2;
         end
         S_CSUM2: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = acc_ff;
            alu_req.b  = ALU_W'(store_ff[PWR_LO_POS]);
            store_in[PACKET_BYTES-1] = alu_res[BYTE_W-1:0];
            prev_in    = now_ff;
            state_in   = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = store_ff[emit_idx_ff];
               rsp_last_in  = (emit_idx_ff == LAST_IDX);
               if (emit_idx_ff == LAST_IDX) begin
                  emit_idx_in = '0;
                  state_in    = S_IDLE;
               end else begin
                  emit_idx_in = emit_idx_ff + IDX_W'(1);
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ceiling_ff   <= CEIL_RST;
         def_ofs_ff   <= DEF_RST;
         third_ff     <= THIRD_RST;
         fourth_ff    <= FOURTH_RST;
         csum_ff      <= CSUM_RST;
         for (int i = 0; i < PACKET_BYTES; i++) begin
            store_ff[i] <= '0;
         end
         pos_ff       <= '0;
         now_ff       <= '0;
         prev_ff      <= '0;
         run_ff       <= '0;
         offset_ff    <= DEF_RST;
         state_ff     <= S_IDLE;
         emit_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ceiling_ff   <= ceiling_in;
         def_ofs_ff   <= def_ofs_in;
         third_ff     <= third_in;
         fourth_ff    <= fourth_in;
         csum_ff      <= csum_in;
         store_ff     <= store_in;
         pos_ff       <= pos_in;
         now_ff       <= now_in;
         prev_ff      <= prev_in;
         run_ff       <= run_in;
         offset_ff    <= offset_in;
         state_ff     <= state_in;
         emit_idx_ff  <= emit_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_FULL)
      else $error("byte position past packet size");

   a_tick_start: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tuser |=> state_ff == S_AVG)
      else $error("tick did not start the average step");

   a_idx_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_EMIT |-> emit_idx_ff == '0)
      else $error("emit index not parked outside emit");

   a_clamp: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLAMP |=> now_ff <= $past(ceiling_ff))
      else $error("demand above ceiling after clamp");

   a_end_pos: assert property (@(posedge clock) disable iff (reset)
      req_fire && !req_tuser && req_tlast |=> pos_ff == '0 && state_ff == S_FIN)
      else $error("packet end did not rewind position");

endmodule

`default_nettype wire

// ===== hdl/pdpr_alu.sv =====
// Shared add/subtract unit used by the sequencer for the offset add, ceiling compare, average and checksum steps.
// Depends on pdpr_pkg.
`default_nettype none

module pdpr_alu
   import pdpr_pkg::*;
(
   input  wire alu_req_type      req,
   output logic [ALU_W-1:0]      result
);

   logic [ALU_W-1:0] b_eff;

   always_comb begin
      b_eff  = (req.op == ALU_SUB) ? ~req.b : req.b;
      result = req.a + b_eff + ALU_W'(req.op == ALU_SUB);
   end

endmodule

`default_nettype wire

// ===== dv/power_demand_packet_rewriter_unit_tb.sv =====
// Self-checking testbench for power_demand_packet_rewriter_unit: streams packet bytes
// and transmit ticks, predicts every rewritten packet and compares each output word.
// Depends on pdpr_pkg and the RTL of the block only.
`default_nettype none

module power_demand_packet_rewriter_unit_tb;
   import pdpr_pkg::*;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef struct packed {
      logic             op;
      logic [7:0]       value;
      logic             last;
   } meter_word_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } out_word_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [BYTE_W-1:0]     req_tdata;
   logic                  req_tuser;
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [BYTE_W-1:0]     rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   power_demand_packet_rewriter_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // register shadows
   logic [CEIL_W-1:0]   ceiling;
   logic [OFFS_W-1:0]   def_ofs;
   logic [OFFS_W-1:0]   third_ofs;
   logic [OFFS_W-1:0]   fourth_ofs;
   logic [CSUM_W-1:0]   csum_base;

   // predicted block state
   logic [7:0]          meter_bytes [PACKET_BYTES_DEF];
   int unsigned         fill_pos;
   logic [DEMAND_W-1:0] demand_cur;
   logic [DEMAND_W-1:0] demand_old;
   logic [RUN_W-1:0]    neg_run;
   logic [OFFS_W-1:0]   live_offset;

   meter_word_type pending_words [$];
   out_word_type   expected_out_bytes [$];
   meter_word_type offer_word;
   logic        offer_taken;
   int          queued_total;
   int          accepted_total;
   int          fail_count;
   int          send_idle_pct;
   int          recv_idle_pct;
   int          hold_off_cycles;

   always #5 clock = ~clock;

   task automatic predict_rewrite(input meter_word_type w);
      logic [15:0] watts;
      int unsigned demand;
      logic [12:0] mean;
      int          ck;
      int          k;
      if (w.op == OP_BYTE) begin
         if (fill_pos < PACKET_BYTES_DEF) begin
            meter_bytes[fill_pos] = w.value;
            fill_pos++;
         end
         if (w.last) begin
            watts = {meter_bytes[PWR_HI_POS], meter_bytes[PWR_LO_POS]};
            if (watts[15]) begin
               neg_run = neg_run + 1'b1;
               if (neg_run == RUN_THIRD)
                  live_offset = third_ofs;
               else if (neg_run == RUN_FOURTH)
                  live_offset = fourth_ofs;
               else
                  live_offset = def_ofs;
               demand = live_offset;
            end else begin
               demand = watts + live_offset;
               neg_run = '0;
            end
            if (demand > ceiling)
               demand = ceiling;
            demand_cur = demand[DEMAND_W-1:0];
            fill_pos = 0;
         end
      end else begin
         mean = ({1'b0, demand_cur} + {1'b0, demand_old}) >> 1;
         meter_bytes[PWR_HI_POS] = 8'(mean >> 8);
         meter_bytes[PWR_LO_POS] = mean[7:0];
         ck = int'(csum_base) - int'(meter_bytes[PWR_HI_POS]) - int'(meter_bytes[PWR_LO_POS]);
         meter_bytes[PACKET_BYTES_DEF-1] = 8'(ck);
         for (k = 0; k < PACKET_BYTES_DEF; k++)
            expected_out_bytes.push_back('{meter_bytes[k], k == PACKET_BYTES_DEF - 1});
         demand_old = demand_cur;
      end
   endtask

   // input side: accept at the rising edge, offer the next word at the falling edge
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         predict_rewrite(offer_word);
         accepted_total++;
         offer_taken = 1'b1;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || offer_taken) begin
         offer_taken = 1'b0;
         if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            offer_word = pending_words.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= offer_word.op;
            req_tdata  <= offer_word.value;
            req_tlast  <= offer_word.last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // output side
   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_off_cycles--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      out_word_type exp_w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_out_bytes.size() == 0) begin
            $display("%0t: unexpected word, expected none, got out_byte %02h out_last %0b",
                     $time, rsp_tdata, rsp_tlast);
            fail_count++;
         end else begin
            exp_w = expected_out_bytes.pop_front();
            if (rsp_tdata !== exp_w.data) begin
               $display("%0t: out_byte expected %02h got %02h", $time, exp_w.data, rsp_tdata);
               fail_count++;
            end
            if (rsp_tlast !== exp_w.last) begin
               $display("%0t: out_last expected %0b got %0b", $time, exp_w.last, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   task automatic push_word(input logic op, input logic [7:0] value, input logic last);
      pending_words.push_back('{op, value, last});
      queued_total++;
   endtask

   task automatic push_packet(input logic [7:0] hi, input logic [7:0] lo, input int len);
      logic [7:0] b;
      int         i;
      for (i = 0; i < len; i++) begin
         b = (i == PWR_HI_POS) ? hi : (i == PWR_LO_POS) ? lo : 8'($urandom);
         push_word(OP_BYTE, b, i == len - 1);
      end
   endtask

   // mostly well-formed packet runs followed by ticks, some noise
   task automatic random_batch(input int count);
      int          start;
      int          npk;
      int          j;
      int          len;
      logic        all_neg;
      logic [15:0] watts;
      start = queued_total;
      while (queued_total - start < count) begin
         if ($urandom_range(99) < 10) begin
            push_word(1'($urandom_range(7) == 0), 8'($urandom), 1'($urandom_range(9) == 0));
         end else begin
            npk = $urandom_range(1, 5);
            all_neg = 1'($urandom);
            for (j = 0; j < npk; j++) begin
               len = ($urandom_range(9) == 0) ? $urandom_range(1, 12) : PACKET_BYTES_DEF;
               case ($urandom_range(2))
                  0: watts = 16'($urandom);
                  1: watts = 16'($urandom_range(0, 4095));
                  default: watts = {1'b1, 15'($urandom)};
               endcase
               if (all_neg)
                  watts[15] = 1'b1;
               push_packet(watts[15:8], watts[7:0], len);
            end
            if ($urandom_range(9) < 7)
               push_word(OP_TICK, 8'($urandom), 1'($urandom));
            if ($urandom_range(9) == 0)
               push_word(OP_TICK, 8'($urandom), 1'($urandom));
         end
      end
   endtask

   task automatic wait_drained;
      while (accepted_total != queued_total || expected_out_bytes.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         REG_CEILING: ceiling    = data[CEIL_W-1:0];
         REG_DEF_OFS: def_ofs    = data[OFFS_W-1:0];
         REG_THIRD:   third_ofs  = data[OFFS_W-1:0];
         REG_FOURTH:  fourth_ofs = data[OFFS_W-1:0];
         REG_CSUM:    csum_base  = data[CSUM_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [CEIL_W-1:0] ceil_v, input logic [OFFS_W-1:0] def_v,
                                 input logic [OFFS_W-1:0] third_v,
                                 input logic [OFFS_W-1:0] fourth_v,
                                 input logic [CSUM_W-1:0] base_v);
      write_reg(REG_CEILING, ceil_v);
      write_reg(REG_DEF_OFS, {2'($urandom), def_v});
      write_reg(REG_THIRD, {2'($urandom), third_v});
      write_reg(REG_FOURTH, {2'($urandom), fourth_v});
      write_reg(REG_CSUM, {3'($urandom), base_v});
      // indexes past the last register must be ignored
      write_reg(CSR_IDX_W'(REG_CSUM + 1), 12'($urandom));
      write_reg(CSR_IDX_W'(REG_CSUM + 3), 12'($urandom));
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int i;
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      req_tlast = 1'b0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      offer_taken = 1'b0;
      offer_word = '0;
      queued_total = 0;
      accepted_total = 0;
      fail_count = 0;
      hold_off_cycles = 0;
      send_idle_pct = 20;
      recv_idle_pct = 64;
      ceiling = CEIL_RST;
      def_ofs = DEF_RST;
      third_ofs = THIRD_RST;
      fourth_ofs = FOURTH_RST;
      csum_base = CSUM_RST;
      for (i = 0; i < PACKET_BYTES_DEF; i++)
         meter_bytes[i] = '0;
      fill_pos = 0;
      demand_cur = '0;
      demand_old = '0;
      neg_run = '0;
      live_offset = DEF_RST;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: tick from reset, max positive reading, overlong negative, short packet
      push_word(OP_TICK, 8'h00, 1'b0);
      push_packet(8'h7F, 8'hFF, PACKET_BYTES_DEF);
      push_word(OP_TICK, 8'h00, 1'b0);
      push_packet(8'h80, 8'h00, 10);
      push_word(OP_TICK, 8'hFF, 1'b1);
      push_word(OP_BYTE, 8'hFF, 1'b1);
      push_word(OP_TICK, 8'h5A, 1'b0);
      wait_drained();

      // all registers at minimum, long receiver hold-off to back up the input
      apply_settings('0, '0, '0, '0, '0);
      random_batch(55);
      hold_off_cycles = 400;
      wait_drained();

      send_idle_pct = 64;
      recv_idle_pct = 20;
      apply_settings('1, '1, '1, '1, '1);
      random_batch(55);
      wait_drained();

      // offsets above the ceiling
      apply_settings(12'd200, 10'd1000, 10'd900, 10'd800, 9'($urandom));
      random_batch(30);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      apply_settings(12'($urandom_range(1100, 4095)), 10'($urandom), 10'($urandom),
                     10'($urandom), 9'($urandom));
      random_batch(55);
      wait_drained();

      if (fail_count == 0 && expected_out_bytes.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

`default_nettype wire
